@@ rtl/sha_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha_pkg;
   localparam logic [7:0] PadByte = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_DRAIN, ST_ROUND, ST_ADD, ST_EMIT
   } core_state_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
         32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
         32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
         32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
         32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
         32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
         32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
         32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
         32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
         32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
         32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] h [8];
      h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
            32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
      return h[i];
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int r);
      return (x >> r) | (x << (32 - r));
   endfunction
endpackage

@@ rtl/sha_item_fifo.sv @@
// Short queue of input items between the front and the compression core.
`timescale 1ns / 1ps
module sha_item_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sha_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output sha_pkg::item_type pop_item,
   output logic              empty
);
   import sha_pkg::*;
   item_type   mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;

   assign full     = cnt_ff[2];
   assign empty    = (cnt_ff == 3'd0);
   assign pop_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_item;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 2'd1;
         if (pop && !empty) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push && !full} - {2'd0, pop && !empty};
      end
   end
endmodule

@@ rtl/sha_core.sv @@
// Back part: block buffer, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sha_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sha_pkg::item_type in_item,
   output logic              in_take,
   output logic [63:0]       rsp_digest_word,
   output logic [1:0]        rsp_word_index,
   output logic              rsp_last_word,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import sha_pkg::*;
   core_state_type state_ff, state_in;
   logic [7:0]  blk_ff [64];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  rnd_ff;
   logic        last_ff, second_ff, next_pad_ff;
   logic [1:0]  widx_ff;
   logic [5:0]  ld_ff;
   logic [5:0]  ld_pos_ff;
   logic        ld_valid_ff;
   logic        pad_mode_ff, pad80_ff, len_ff;
   logic [5:0]  pfill_ff;
   logic [7:0]  rd_byte_ff;
   logic [7:0]  ld_byte;
   logic        do_final, full_block;
   logic [5:0]  pend;
   logic [31:0] s0, s1, wn, t1, t2;

   assign in_take    = (state_ff == ST_IDLE) && in_valid;
   assign do_final   = in_item.end_of_message;
   assign full_block = in_item.byte_present && (fill_ff == 6'd63);
   assign pend       = fill_ff + {5'd0, in_item.byte_present};

   always_comb begin
      s0 = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wn = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
           + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + w_ff[0];
      t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (in_valid && (full_block || do_final)) state_in = ST_LOAD;
         ST_LOAD:  if (ld_ff == 6'd63) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD:   state_in = second_ff ? ST_LOAD : (last_ff ? ST_EMIT : ST_IDLE);
         ST_EMIT:  if (rsp_pop && widx_ff == 2'd3) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_empty       = (state_ff != ST_EMIT);
      rsp_word_index  = widx_ff;
      rsp_last_word   = (widx_ff == 2'd3);
      rsp_digest_word = {h_ff[{widx_ff, 1'b0}], h_ff[{widx_ff, 1'b1}]};
   end

   // Load reads one byte per cycle; the read is registered before it feeds w.
   always_ff @(posedge clock) begin
      rd_byte_ff <= blk_ff[ld_ff];
      ld_pos_ff  <= ld_ff;
      if (in_take && in_item.byte_present)
         blk_ff[fill_ff] <= in_item.data_byte;
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         bits_ff     <= '0;
         widx_ff     <= '0;
         ld_ff       <= '0;
         rnd_ff      <= '0;
         last_ff     <= 1'b0;
         second_ff   <= 1'b0;
         next_pad_ff <= 1'b0;
         ld_valid_ff <= 1'b0;
         pad_mode_ff <= 1'b0;
         pad80_ff    <= 1'b0;
         len_ff      <= 1'b0;
         pfill_ff    <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (in_valid) begin
               if (in_item.byte_present) begin
                  fill_ff <= fill_ff + 6'd1;
                  bits_ff <= bits_ff + 64'd8;
               end
               ld_ff <= '0;
               ld_valid_ff <= 1'b0;
               last_ff <= do_final;
               if (full_block) begin
                  // A final item that fills the block needs a block with the pad byte.
                  pad_mode_ff <= 1'b0;
                  second_ff <= do_final;
                  next_pad_ff <= 1'b1;
               end else begin
                  pad_mode_ff <= 1'b1;
                  pfill_ff <= pend;
                  pad80_ff <= 1'b1;
                  len_ff <= (pend < 6'd56);
                  second_ff <= (pend > 6'd55);
                  next_pad_ff <= 1'b0;
               end
            end
            ST_LOAD: begin
               ld_ff <= ld_ff + 6'd1;
               ld_valid_ff <= 1'b1;
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_DRAIN: ld_valid_ff <= 1'b0;
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               fill_ff <= '0;
               ld_ff <= '0;
               widx_ff <= '0;
               if (second_ff) begin
                  // The follow-up block holds zeros and the length, with the pad byte if due.
                  second_ff <= 1'b0;
                  pad_mode_ff <= 1'b1;
                  pfill_ff <= '0;
                  pad80_ff <= next_pad_ff;
                  len_ff <= 1'b1;
               end
            end
            ST_EMIT: if (rsp_pop) begin
               widx_ff <= widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
                  bits_ff <= '0;
                  fill_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (!pad_mode_ff) ld_byte = rd_byte_ff;
      else if (len_ff && ld_pos_ff >= 6'd56)
         ld_byte = bits_ff[{~ld_pos_ff[2:0], 3'b000} +: 8];
      else if (ld_pos_ff < pfill_ff) ld_byte = rd_byte_ff;
      else if (pad80_ff && ld_pos_ff == pfill_ff) ld_byte = PadByte;
      else ld_byte = 8'd0;
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_LOAD || state_ff == ST_DRAIN) && ld_valid_ff) begin
         w_ff[ld_pos_ff[5:2]] <= {w_ff[ld_pos_ff[5:2]][23:0], ld_byte};
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wn;
      end
   end
endmodule

@@ rtl/sha_front.sv @@
// Front part: takes input items, drops empty ones and queues the rest.
`timescale 1ns / 1ps
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_data_byte,
   input  logic              req_byte_present,
   input  logic              req_end_of_message,
   output logic              req_full,
   input  logic              core_take,
   output logic              core_valid,
   output sha_pkg::item_type core_item
);
   import sha_pkg::*;
   item_type it;
   logic     useful, q_empty;
   assign it     = '{data_byte: req_data_byte, byte_present: req_byte_present,
                     end_of_message: req_end_of_message};
   assign useful = req_byte_present || req_end_of_message;
   assign core_valid = !q_empty;
   sha_item_fifo u_fifo (
      .clock, .reset, .push(req_push && useful), .push_item(it), .full(req_full),
      .pop(core_take), .pop_item(core_item), .empty(q_empty));
endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: top level.
// An item waiting in the queue is taken by the core whenever the core is idle.
// A block is loaded, drained, put through the 64 rounds and added into the hash.
// A final item's first digest word appears once its block is done, or once a second block
// is done when padding needs one; one word then leaves per pop.
// Throughput: one byte per cycle until a block fills or a message ends; the 4-entry queue then holds input off.
// Reset: synchronous, restores initial hash values and clears counters.
`timescale 1ns / 1ps
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;
   item_type item;
   logic     valid, take;
   sha_front u_front (
      .clock, .reset, .req_push, .req_data_byte, .req_byte_present, .req_end_of_message,
      .req_full, .core_take(take), .core_valid(valid), .core_item(item));
   sha_core u_core (
      .clock, .reset, .in_valid(valid), .in_item(item), .in_take(take),
      .rsp_digest_word, .rsp_word_index, .rsp_last_word, .rsp_empty, .rsp_pop);
endmodule

@@ rtl/sha_checker.sv @@
// Port checker for the SHA-256 stream hasher, bound to the top level.
`timescale 1ns / 1ps
module sha_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [1:0] rsp_word_index,
   input logic       rsp_last_word
);
   a_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_word == (rsp_word_index == 2'd3))) else $error("last_word");
   a_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_word) |=> (!rsp_empty &&
      rsp_word_index == $past(rsp_word_index) + 2'd1)) else $error("word order");
   a_first: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_empty)) |-> rsp_word_index == 2'd0) else $error("first word");
endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
